>>> sv/rar_pkg.sv
// ============================================================================
// rar_pkg
// Shared widths, operation codes, queue entry type and state encodings for
// the rational arithmetic and reduction block.
// ============================================================================
`default_nettype none

package rar_pkg;

    // Operand width taken from each input field (at most the field width).
    localparam int OPERAND_WIDTH = 16;
    localparam int IN_W          = 16;
    localparam int PROD_W        = 2 * OPERAND_WIDTH;
    localparam int RAW_W         = PROD_W + 1;
    localparam int MAG_W         = RAW_W;
    localparam int RES_W         = 33;
    localparam int SHIFT_W       = $clog2(MAG_W + 1);
    localparam int DIV_CNT_W     = $clog2(MAG_W);
    localparam int Q_DEPTH       = 2;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);
    localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } t_kind;

    // Raw fraction handed from the front end to the reduction engine.
    typedef struct packed {
        logic [RAW_W-1:0] num;
        logic [RAW_W-1:0] den;
        logic             zero_den;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MUL,
        FR_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_GCD,
        BK_SCALE,
        BK_DIV,
        BK_DONE
    } t_back_state;

    function automatic logic [MAG_W-1:0] magnitude(input logic [RAW_W-1:0] v);
        logic [MAG_W-1:0] m;
        m = MAG_W'(v);
        return v[RAW_W-1] ? (~m + MAG_W'(1)) : m;
    endfunction

    function automatic logic [RES_W-1:0] apply_sign(input logic [MAG_W-1:0] mag,
                                                    input logic neg);
        logic [MAG_W-1:0] t;
        t = neg ? (~mag + MAG_W'(1)) : mag;
        return RES_W'($signed(t));
    endfunction

endpackage

`default_nettype wire

>>> sv/rar_if.sv
// ============================================================================
// rar_in_if / rar_out_if
// Valid/ready channels for the operand items and the reduced results.
// ============================================================================
`default_nettype none

interface rar_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] a_num;
    logic [15:0] a_den;
    logic [15:0] b_num;
    logic [15:0] b_den;

    modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_out_if;
    logic        valid;
    logic        ready;
    logic [32:0] res_num;
    logic [32:0] res_den;
    logic        zero_den;

    modport source (output valid, res_num, res_den, zero_den, input ready);
    modport sink   (input valid, res_num, res_den, zero_den, output ready);
endinterface

`default_nettype wire

>>> sv/rar_front.sv
// ============================================================================
// rar_front
// Accepts an operand item, forms the cross products and the raw numerator and
// denominator, flags a zero denominator and pushes the job into the queue.
// ============================================================================
`default_nettype none

module rar_front
    import rar_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    rar_in_if.sink         i_op,
    input  wire t_q_status i_q_status,
    output logic           o_push,
    output t_job           o_job
);

    t_front_state r_state, n_state;

    t_kind                     r_kind;
    logic signed [OPERAND_WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [PROD_W-1:0]  r_p_n1, r_p_n2, r_p_d;

    logic                      w_accept;
    logic signed [RAW_W-1:0]   w_n1, w_n2, w_num, w_den;

    assign i_op.ready = (r_state == FR_IDLE);
    assign w_accept   = i_op.valid && (r_state == FR_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Operand capture and the three products, each registered.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= t_kind'(i_op.kind);
            r_an   <= i_op.a_num[OPERAND_WIDTH-1:0];
            r_ad   <= i_op.a_den[OPERAND_WIDTH-1:0];
            r_bn   <= i_op.b_num[OPERAND_WIDTH-1:0];
            r_bd   <= i_op.b_den[OPERAND_WIDTH-1:0];
        end
        if (r_state == FR_MUL) begin
            r_p_n1 <= r_an * ((r_kind == KIND_MUL) ? r_bn : r_bd);
            r_p_n2 <= r_bn * r_ad;
            r_p_d  <= r_ad * ((r_kind == KIND_DIV) ? r_bn : r_bd);
        end
    end

    assign w_n1  = RAW_W'(r_p_n1);
    assign w_n2  = RAW_W'(r_p_n2);
    assign w_den = RAW_W'(r_p_d);

    always_comb begin
        case (r_kind)
            KIND_ADD: w_num = w_n1 + w_n2;
            KIND_SUB: w_num = w_n1 - w_n2;
            default:  w_num = w_n1;
        endcase
    end

    assign o_job.num      = w_num;
    assign o_job.den      = w_den;
    assign o_job.zero_den = (r_p_d == '0);

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        case (r_state)
            FR_IDLE: begin
                if (i_op.valid) begin
                    n_state = FR_MUL;
                end
            end
            FR_MUL: begin
                n_state = FR_PUSH;
            end
            FR_PUSH: begin
                if (!i_q_status.full) begin
                    o_push  = 1'b1;
                    n_state = FR_IDLE;
                end
            end
            default: begin
                n_state = FR_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/rar_queue.sv
// ============================================================================
// rar_queue
// Short first-in first-out queue of raw jobs between front end and engine.
// ============================================================================
`default_nettype none

module rar_queue
    import rar_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_job  i_job,
    input  wire logic  i_pop,
    output t_job       o_job,
    output t_q_status  o_status
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               w_wr, w_rd;

    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_wr           = i_push && !o_status.full;
    assign w_rd           = i_pop && !o_status.empty;
    assign o_job          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/rar_back.sv
// ============================================================================
// rar_back
// Reduction engine: binary gcd of the magnitudes, one step a cycle, then two
// restoring dividers sharing the gcd as divisor, one quotient bit a cycle.
// ============================================================================
`default_nettype none

module rar_back
    import rar_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_job      i_job,
    input  wire t_q_status i_q_status,
    output logic           o_pop,
    rar_out_if.source      o_res
);

    t_back_state r_state, n_state;

    logic                 r_num_neg, n_num_neg;
    logic                 r_den_neg, n_den_neg;
    logic                 r_zero, n_zero;
    logic [RAW_W-1:0]     r_raw_num, n_raw_num;
    logic [MAG_W-1:0]     r_mag_n, n_mag_n;
    logic [MAG_W-1:0]     r_mag_d, n_mag_d;
    logic [MAG_W-1:0]     r_u, n_u;
    logic [MAG_W-1:0]     r_v, n_v;
    logic [SHIFT_W-1:0]   r_k, n_k;
    logic [MAG_W-1:0]     r_g, n_g;
    logic [MAG_W-1:0]     r_qn, n_qn;
    logic [MAG_W-1:0]     r_qd, n_qd;
    logic [MAG_W-1:0]     r_rem_n, n_rem_n;
    logic [MAG_W-1:0]     r_rem_d, n_rem_d;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic [RES_W-1:0]     r_res_num, n_res_num;
    logic [RES_W-1:0]     r_res_den, n_res_den;
    logic                 r_res_zero, n_res_zero;

    logic [MAG_W:0]       w_trial_n, w_trial_d, w_div_ext;

    assign o_res.valid    = r_out_valid;
    assign o_res.res_num  = r_res_num;
    assign o_res.res_den  = r_res_den;
    assign o_res.zero_den = r_res_zero;

    assign w_div_ext = {1'b0, r_g};
    assign w_trial_n = {r_rem_n, r_qn[MAG_W-1]};
    assign w_trial_d = {r_rem_d, r_qd[MAG_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num_neg  <= n_num_neg;
        r_den_neg  <= n_den_neg;
        r_zero     <= n_zero;
        r_raw_num  <= n_raw_num;
        r_mag_n    <= n_mag_n;
        r_mag_d    <= n_mag_d;
        r_u        <= n_u;
        r_v        <= n_v;
        r_k        <= n_k;
        r_g        <= n_g;
        r_qn       <= n_qn;
        r_qd       <= n_qd;
        r_rem_n    <= n_rem_n;
        r_rem_d    <= n_rem_d;
        r_cnt      <= n_cnt;
        r_res_num  <= n_res_num;
        r_res_den  <= n_res_den;
        r_res_zero <= n_res_zero;
    end

    always_comb begin
        n_state     = r_state;
        n_num_neg   = r_num_neg;
        n_den_neg   = r_den_neg;
        n_zero      = r_zero;
        n_raw_num   = r_raw_num;
        n_mag_n     = r_mag_n;
        n_mag_d     = r_mag_d;
        n_u         = r_u;
        n_v         = r_v;
        n_k         = r_k;
        n_g         = r_g;
        n_qn        = r_qn;
        n_qd        = r_qd;
        n_rem_n     = r_rem_n;
        n_rem_d     = r_rem_d;
        n_cnt       = r_cnt;
        n_res_num   = r_res_num;
        n_res_den   = r_res_den;
        n_res_zero  = r_res_zero;
        n_out_valid = r_out_valid && !o_res.ready;
        o_pop       = 1'b0;

        case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop     = 1'b1;
                    n_num_neg = i_job.num[RAW_W-1];
                    n_den_neg = i_job.den[RAW_W-1];
                    n_zero    = i_job.zero_den;
                    n_raw_num = i_job.num;
                    n_mag_n   = magnitude(i_job.num);
                    n_mag_d   = magnitude(i_job.den);
                    n_u       = magnitude(i_job.num);
                    n_v       = magnitude(i_job.den);
                    n_k       = '0;
                    n_state   = i_job.zero_den ? BK_DONE : BK_GCD;
                end
            end
            BK_GCD: begin
                // The denominator magnitude is never zero here, so the loop
                // ends when u has been worn down to zero.
                if (r_u == '0) begin
                    n_state = BK_SCALE;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + SHIFT_W'(1);
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (r_u >= r_v) begin
                    n_u = (r_u - r_v) >> 1;
                end else begin
                    n_v = (r_v - r_u) >> 1;
                end
            end
            BK_SCALE: begin
                n_g     = r_v << r_k;
                n_qn    = r_mag_n;
                n_qd    = r_mag_d;
                n_rem_n = '0;
                n_rem_d = '0;
                n_cnt   = DIV_CNT_W'(MAG_W - 1);
                n_state = BK_DIV;
            end
            BK_DIV: begin
                if (w_trial_n >= w_div_ext) begin
                    n_rem_n = MAG_W'(w_trial_n - w_div_ext);
                    n_qn    = {r_qn[MAG_W-2:0], 1'b1};
                end else begin
                    n_rem_n = w_trial_n[MAG_W-1:0];
                    n_qn    = {r_qn[MAG_W-2:0], 1'b0};
                end
                if (w_trial_d >= w_div_ext) begin
                    n_rem_d = MAG_W'(w_trial_d - w_div_ext);
                    n_qd    = {r_qd[MAG_W-2:0], 1'b1};
                end else begin
                    n_rem_d = w_trial_d[MAG_W-1:0];
                    n_qd    = {r_qd[MAG_W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    n_state = BK_DONE;
                end else begin
                    n_cnt = r_cnt - DIV_CNT_W'(1);
                end
            end
            BK_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_res_zero  = r_zero;
                    if (r_zero) begin
                        // Zero denominator: raw pair is passed on unreduced.
                        n_res_num = RES_W'($signed(r_raw_num));
                        n_res_den = '0;
                    end else begin
                        n_res_num = apply_sign(r_qn, r_num_neg);
                        n_res_den = apply_sign(r_qd, r_den_neg);
                    end
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/rational_arith_reduce.sv
// The front end captures the operands, forms the products and pushes the raw job;
// the reduction engine pops it, runs the binary gcd steps, scales the gcd, runs the
// dividers and presents the result. A zero denominator skips the gcd and divide.
// The engine finishes one item before it pops the next, paced by the gcd loop and
// the bit-serial dividers; the front end works ahead into a 2-entry queue.
// Reset is synchronous, active low, and clears the state machines, queue and valid.
// ============================================================================
// rational_arith_reduce
// Arithmetic on two signed fractions with reduction by the gcd of the
// magnitudes of the raw numerator and denominator.
// ============================================================================
`default_nettype none

module rational_arith_reduce
    import rar_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rar_in_if.sink    i_op,
    rar_out_if.source o_res
);

    logic      w_push;
    logic      w_pop;
    t_job      w_push_job;
    t_job      w_head_job;
    t_q_status w_q_status;

    rar_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (i_op),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    rar_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_job    (w_head_job),
        .o_status (w_q_status)
    );

    rar_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_head_job),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_res      (o_res)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_rational_arith_reduce.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_rational_arith_reduce
// Self-checking bench for the fraction arithmetic and reduction block. A short
// table of directed operands runs first, some rows with typed-in answers, then
// a long stream of random operands checked against a behavioural predictor.
// Both channels idle at random, the result side holds off once for a long
// stretch and the operand side pauses once until every result has drained.
// ============================================================================

module tb_rational_arith_reduce;
    import rar_pkg::*;

    localparam int  N_RANDOM     = 1730;
    localparam int  IDLE_PCT     = 18;
    localparam int  CALM_FIRST   = 700;
    localparam int  CALM_LAST    = 1000;
    localparam int  HOLD_AT      = 300;
    localparam int  HOLD_CYCLES  = 800;
    localparam int  DRAIN_AT     = 1200;
    localparam int  TAIL_CYCLES  = 150;
    localparam int  CYCLE_LIMIT  = 1_200_000;
    localparam int  PRINT_LIMIT  = 30;

    typedef struct {
        logic [RES_W-1:0] num;
        logic [RES_W-1:0] den;
        logic             zero_den;
        int               seq;
    } t_fraction;

    // One operand set; when has_answer is set the expected fraction is typed in.
    typedef struct {
        t_kind  kind;
        int     a_num;
        int     a_den;
        int     b_num;
        int     b_den;
        bit     has_answer;
        longint want_num;
        longint want_den;
        bit     want_zero;
    } t_operand_row;

    logic i_clk;
    logic i_rst_n;

    rar_in_if  op_if ();
    rar_out_if res_if ();

    rational_arith_reduce u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op_if),
        .o_res   (res_if)
    );

    t_fraction pending_fractions[$];
    int        error_count     = 0;
    int        results_checked = 0;
    int        zero_den_seen   = 0;
    int        items_sent      = 0;
    int        kind_count[4]   = '{0, 0, 0, 0};
    int        cycle_count     = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT) $display("%0t ns: %s", $time, what);
    endtask

    function automatic logic [63:0] widen_operand(input logic [IN_W-1:0] v);
        logic [63:0] mask;
        logic [63:0] w;
        mask = (64'd1 << OPERAND_WIDTH) - 64'd1;
        w = 64'(v) & mask;
        if (w[OPERAND_WIDTH-1]) w = w | ~mask;
        return w;
    endfunction

    function automatic logic [63:0] abs_u64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // Raw products wrap at 64 bits; both parts are then divided by the gcd of
    // their magnitudes, each keeping its own sign.
    function automatic t_fraction reduce_fraction(input t_kind kind,
                                                  input logic [IN_W-1:0] a_n,
                                                  input logic [IN_W-1:0] a_d,
                                                  input logic [IN_W-1:0] b_n,
                                                  input logic [IN_W-1:0] b_d);
        logic [63:0] an, ad, bn, bd, num, den, x, y, r, q;
        t_fraction   res;
        an = widen_operand(a_n);
        ad = widen_operand(a_d);
        bn = widen_operand(b_n);
        bd = widen_operand(b_d);
        case (kind)
            KIND_ADD: begin
                num = an * bd + bn * ad;
                den = ad * bd;
            end
            KIND_SUB: begin
                num = an * bd - bn * ad;
                den = ad * bd;
            end
            KIND_MUL: begin
                num = an * bn;
                den = ad * bd;
            end
            default: begin
                num = an * bd;
                den = ad * bn;
            end
        endcase
        res.seq = 0;
        if (den == 64'd0) begin
            res.num      = num[RES_W-1:0];
            res.den      = '0;
            res.zero_den = 1'b1;
            return res;
        end
        x = abs_u64(num);
        y = abs_u64(den);
        while (y != 64'd0) begin
            r = x % y;
            x = y;
            y = r;
        end
        q = abs_u64(num) / x;
        if (num[63]) q = 64'd0 - q;
        res.num = q[RES_W-1:0];
        q = abs_u64(den) / x;
        if (den[63]) q = 64'd0 - q;
        res.den      = q[RES_W-1:0];
        res.zero_den = 1'b0;
        return res;
    endfunction

    function automatic int pick_operand(input int style, input int factor);
        int corners[6];
        corners = '{-32768, -32767, -1, 0, 1, 32767};
        case (style)
            0:       return int'($urandom_range(0, 65535)) - 32768;
            1:       return int'($urandom_range(0, 80)) - 40;
            2:       return factor * (int'($urandom_range(0, 362)) - 181);
            default: return corners[$urandom_range(0, 5)];
        endcase
    endfunction

    // Mostly operands that share factors or are small, so that reduction does
    // real work; the rest are full-range values, corners and zero denominators.
    function automatic t_operand_row random_row();
        t_operand_row row;
        int           sel;
        int           style;
        int           factor;
        sel    = $urandom_range(0, 99);
        style  = (sel < 35) ? 0 : (sel < 60) ? 1 : (sel < 88) ? 2 : 3;
        factor = $urandom_range(1, 181);
        row.kind       = t_kind'($urandom_range(0, 3));
        row.a_num      = pick_operand(style, factor);
        row.a_den      = pick_operand(style, factor);
        row.b_num      = pick_operand(style, factor);
        row.b_den      = pick_operand(style, factor);
        row.has_answer = 1'b0;
        row.want_num   = 0;
        row.want_den   = 0;
        row.want_zero  = 1'b0;
        if ($urandom_range(0, 99) < 7) begin
            case ($urandom_range(0, 2))
                0:       row.a_den = 0;
                1:       row.b_den = 0;
                default: row.b_num = 0;
            endcase
        end
        return row;
    endfunction

    // Drives one operand set from a falling edge, waits for the transfer and
    // records what the block must answer. Returns at the next falling edge.
    task automatic send_operands(input t_operand_row row, input bit may_idle);
        t_fraction want;
        if (may_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            op_if.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        op_if.kind  = row.kind;
        op_if.a_num = IN_W'(row.a_num);
        op_if.a_den = IN_W'(row.a_den);
        op_if.b_num = IN_W'(row.b_num);
        op_if.b_den = IN_W'(row.b_den);
        op_if.valid = 1'b1;
        do @(posedge i_clk); while (!op_if.ready);
        if (row.has_answer) begin
            want.num      = RES_W'(row.want_num);
            want.den      = RES_W'(row.want_den);
            want.zero_den = row.want_zero;
        end else begin
            want = reduce_fraction(row.kind, IN_W'(row.a_num), IN_W'(row.a_den),
                                   IN_W'(row.b_num), IN_W'(row.b_den));
        end
        want.seq = items_sent;
        pending_fractions.push_back(want);
        items_sent++;
        kind_count[row.kind]++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        t_fraction want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_fractions.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d/%0d zero_den=%0b",
                                          $signed(res_if.res_num), $signed(res_if.res_den),
                                          res_if.zero_den));
            end else begin
                want = pending_fractions.pop_front();
                if (res_if.res_num !== want.num || res_if.res_den !== want.den
                    || res_if.zero_den !== want.zero_den)
                    report_mismatch($sformatf(
                        "item %0d: got %0d/%0d zero_den=%0b, expected %0d/%0d zero_den=%0b",
                        want.seq, $signed(res_if.res_num), $signed(res_if.res_den),
                        res_if.zero_den, $signed(want.num), $signed(want.den),
                        want.zero_den));
                if (want.zero_den) zero_den_seen++;
            end
            results_checked++;
        end
    end

    // Result side: random back-pressure, one long hold-off while operands keep
    // coming, and a calm stretch with ready held high.
    initial begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left     = 0;
        hold_done     = 1'b0;
        res_if.ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && results_checked >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                res_if.ready = 1'b0;
                hold_left--;
            end else if (results_checked >= CALM_FIRST && results_checked < CALM_LAST) begin
                res_if.ready = 1'b1;
            end else begin
                res_if.ready = ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timed out after %0d cycles with %0d results outstanding",
                 cycle_count, pending_fractions.size());
        $display("[rational_arith_reduce] ERROR");
        $finish;
    end

    initial begin : stimulus
        t_operand_row directed_rows[20];
        int           n_directed;
        n_directed = 20;
        directed_rows = '{
            '{KIND_ADD,      0,      1,      0,      1, 1,           0,          1, 0},
            '{KIND_MUL,      1,      0,      1,      1, 1,           1,          0, 1},
            '{KIND_ADD,      1,      0,      1,      0, 1,           0,          0, 1},
            '{KIND_DIV,      3,      2,      0,      5, 1,          15,          0, 1},
            '{KIND_DIV, -32768,      1,      0, -32768, 1, 64'd1 << 30,          0, 1},
            '{KIND_ADD,      0,     -3,      0,      5, 1,           0,         -1, 0},
            '{KIND_SUB,      7,      3,      7,      3, 1,           0,          1, 0},
            '{KIND_MUL,     -4,      6,      1,     -2, 1,          -1,         -3, 0},
            '{KIND_MUL,     -1,     -1,     -1,     -1, 1,           1,          1, 0},
            '{KIND_DIV,      1,      2,      3,      4, 1,           2,          3, 0},
            '{KIND_MUL, -32768, -32768, -32768, -32768, 1,           1,          1, 0},
            '{KIND_ADD, -32768,      1, -32768,      1, 1,      -65536,          1, 0},
            '{KIND_SUB, -32768,      1,  32767,      1, 1,      -65535,          1, 0},
            '{KIND_ADD,  32767,      1,  32767,      1, 1,       65534,          1, 0},
            '{KIND_SUB, -32768, -32768,  32767, -32768, 1,       65535,      32768, 0},
            '{KIND_ADD,  32767, -32768, -32768,  32767, 0,           0,          0, 0},
            '{KIND_DIV,  32767,  32767, -32768,     -1, 0,           0,          0, 0},
            '{KIND_MUL,     12,    -18,    -10,     15, 0,           0,          0, 0},
            '{KIND_SUB, -32768,     -1,  32767, -32767, 0,           0,          0, 0},
            '{KIND_ADD,  21845, -21846, -21846,  21845, 0,           0,          0, 0}
        };

        i_rst_n     = 1'b0;
        op_if.valid = 1'b0;
        op_if.kind  = KIND_ADD;
        op_if.a_num = '0;
        op_if.a_den = '0;
        op_if.b_num = '0;
        op_if.b_den = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < n_directed; i++) send_operands(directed_rows[i], 1'b1);

        for (int i = 0; i < N_RANDOM; i++) begin
            // Let the block empty out completely once, with the operand side silent.
            if (items_sent == DRAIN_AT) begin
                op_if.valid = 1'b0;
                while (pending_fractions.size() != 0) @(negedge i_clk);
            end
            send_operands(random_row(), !(items_sent >= CALM_FIRST && items_sent < CALM_LAST));
        end
        op_if.valid = 1'b0;

        while (pending_fractions.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Sent %0d operand sets (%0d directed): add %0d, sub %0d, mul %0d, div %0d.",
                 items_sent, n_directed, kind_count[KIND_ADD], kind_count[KIND_SUB],
                 kind_count[KIND_MUL], kind_count[KIND_DIV]);
        $display("Checked %0d results, %0d with zero denominator, %0d mismatches, %0d cycles.",
                 results_checked, zero_den_seen, error_count, cycle_count);
        if (error_count == 0) begin
            $display("[rational_arith_reduce] OK");
        end else begin
            $display("[rational_arith_reduce] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/rar_pkg.sv
sv/rar_if.sv
sv/rar_front.sv
sv/rar_queue.sv
sv/rar_back.sv
sv/rational_arith_reduce.sv
tb/sv/tb_rational_arith_reduce.sv
